// File: design/slbs_pkg.sv
package slbs_pkg;

  localparam int unsigned PatWidth   = 36;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 36;
  localparam logic [31:0] MinStepMs  = 32'd10;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_ON       = 2'd1,
    PH_GAP      = 2'd2,
    PH_INTERVAL = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    PAT_BATTERY = 3'd0,
    PAT_IMU     = 3'd1,
    PAT_WIFI    = 3'd2,
    PAT_SERVER  = 3'd3,
    PAT_STANDBY = 3'd4,
    PAT_NONE    = 3'd5
  } pat_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_BATTERY = 3'd0,
    CFG_IMU_ERROR   = 3'd1,
    CFG_WIFI        = 3'd2,
    CFG_SERVER      = 3'd3,
    CFG_GAP         = 3'd4,
    CFG_STANDBY     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  status_bits;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       led_lit;
    logic [2:0] active_pattern;
  } out_item_t;

  // Pattern words: [3:0] count, [19:4] on length, [35:20] interval.
  typedef struct packed {
    logic [3:0][PatWidth-1:0] patterns;
    logic [15:0]              gap_length;
    logic [31:0]              standby_pattern;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  flags;
    phase_e      phase;
    logic [3:0]  blink_count;
    logic [15:0] timer;   // zero, or an elapsed sum below the phase length at its update
    logic [31:0] last_ms;
    logic        led;
  } state_t;

  function automatic pat_e select_pattern(logic [3:0] flags, logic [31:0] standby);
    pat_e p;
    if (flags[0]) p = PAT_BATTERY;
    else if (flags[1]) p = PAT_IMU;
    else if (flags[2]) p = PAT_WIFI;
    else if (flags[3]) p = PAT_SERVER;
    else if (standby[31:16] != 16'd0) p = PAT_STANDBY;
    else p = PAT_NONE;
    return p;
  endfunction

endpackage

// File: design/slbs_step.sv
module slbs_step (
  input  slbs_pkg::cfg_t     cfg_i,
  input  slbs_pkg::state_t   state_i,
  input  slbs_pkg::in_item_t item_i,
  output slbs_pkg::state_t   state_o,
  output slbs_pkg::out_item_t result_o
);

  logic [31:0]     diff;
  slbs_pkg::pat_e  pat;
  logic [35:0]     word;
  logic [3:0]      count;
  logic [15:0]     on_len;
  logic [15:0]     int_len;
  logic [15:0]     length;
  logic [32:0]     sum;
  logic [3:0]      blink_inc;

  assign diff = item_i.now_ms - state_i.last_ms;
  assign pat  = slbs_pkg::select_pattern(state_i.flags, cfg_i.standby_pattern);
  assign word = cfg_i.patterns[pat[1:0]];

  always_comb begin
    if (pat == slbs_pkg::PAT_STANDBY) begin
      count   = 4'd1;
      on_len  = cfg_i.standby_pattern[15:0];
      int_len = cfg_i.standby_pattern[31:16];
    end else begin
      count   = word[3:0];
      on_len  = word[19:4];
      int_len = word[35:20];
    end
  end

  always_comb begin
    unique case (state_i.phase)
      slbs_pkg::PH_GAP:      length = cfg_i.gap_length;
      slbs_pkg::PH_INTERVAL: length = int_len;
      default:               length = on_len;
    endcase
  end

  // sum compared without wrap
  assign sum       = {1'b0, diff} + {17'd0, state_i.timer};
  assign blink_inc = state_i.blink_count + 4'd1;

  always_comb begin
    state_o = state_i;
    case (item_i.mode)
      slbs_pkg::MODE_TICK: begin
        if (diff >= slbs_pkg::MinStepMs) begin
          state_o.last_ms = item_i.now_ms;
          if (pat != slbs_pkg::PAT_NONE) begin
            if (state_i.phase == slbs_pkg::PH_OFF || sum >= {17'd0, length}) begin
              state_o.timer = 16'd0;
              if (state_i.phase == slbs_pkg::PH_ON) begin
                state_o.led = 1'b0;
                if (blink_inc >= count) begin
                  state_o.blink_count = 4'd0;
                  state_o.phase       = slbs_pkg::PH_INTERVAL;
                end else begin
                  state_o.blink_count = blink_inc;
                  state_o.phase       = slbs_pkg::PH_GAP;
                end
              end else begin
                if (state_i.phase == slbs_pkg::PH_OFF) state_o.blink_count = 4'd0;
                state_o.led   = 1'b1;
                state_o.phase = slbs_pkg::PH_ON;
              end
            end else begin
              state_o.timer = sum[15:0];
            end
          end
        end
      end
      slbs_pkg::MODE_SET:   state_o.flags = state_i.flags | item_i.status_bits;
      slbs_pkg::MODE_CLEAR: state_o.flags = state_i.flags & ~item_i.status_bits;
      default: ;
    endcase
  end

  assign result_o.led_lit        = state_o.led;
  assign result_o.active_pattern =
    slbs_pkg::select_pattern(state_o.flags, cfg_i.standby_pattern);

endmodule

// File: design/status_led_blink_sequencer.sv
// An accepted transaction goes to the input register, and its result to the result register.
// Throughput: one transaction per cycle unless stalled; the step logic is combinational.
// A result held by out_stall_i does not block: one more transaction is taken into the input
// register, and the input stalls only when both registers are full.
// Reset (rst_ni low, asynchronous): pattern registers, status flags, sequencer state and
// the LED clear to zero (off phase, LED dark); both registers empty.
module status_led_blink_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [slbs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [slbs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // input transactions
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  slbs_pkg::in_item_t                in_item_i,
  // result transactions
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output slbs_pkg::out_item_t               out_item_o
);

  slbs_pkg::cfg_t      cfg_q;
  slbs_pkg::state_t    state_q, state_d;
  slbs_pkg::in_item_t  s1_item_q;
  logic                s1_valid_q;
  slbs_pkg::out_item_t out_item_q, result;
  logic                out_valid_q;

  logic out_free;   // result register can take a new result this cycle
  logic advance;    // input register moves into the result register
  logic in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        slbs_pkg::CFG_LOW_BATTERY: cfg_q.patterns[0] <= cfg_wdata_i;
        slbs_pkg::CFG_IMU_ERROR:   cfg_q.patterns[1] <= cfg_wdata_i;
        slbs_pkg::CFG_WIFI:        cfg_q.patterns[2] <= cfg_wdata_i;
        slbs_pkg::CFG_SERVER:      cfg_q.patterns[3] <= cfg_wdata_i;
        slbs_pkg::CFG_GAP:         cfg_q.gap_length <= cfg_wdata_i[15:0];
        slbs_pkg::CFG_STANDBY:     cfg_q.standby_pattern <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept || advance) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_item_q <= in_item_i;
  end

  // Step logic: next sequencer state and the result for the registered transaction
  slbs_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Sequencer state commits only when the transaction moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: design/slbs_checker.sv
module slbs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input slbs_pkg::out_item_t           out_item_o
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // input stalls only when a result is waiting downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // a fresh result needs a transaction that was taken in through the input register
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a transaction");

  a_pattern_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.active_pattern <= slbs_pkg::PAT_NONE)
    else $error("pattern code out of range");

endmodule

bind status_led_blink_sequencer slbs_checker u_slbs_checker (.*);
